FILE: rtl/core/lobm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

    typedef enum logic [1:0] {
        KIND_TRADE   = 2'd0,
        KIND_RESTED  = 2'd1,
        KIND_FILLED  = 2'd2,
        KIND_DROPPED = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] order_id;
        logic        side;
        logic [19:0] limit_price;
        logic [19:0] quantity;
    } t_order;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [19:0] trade_price;
        logic [19:0] trade_qty;
        logic        last;
    } t_result;

    // queued work item: the order plus what the front found out about it
    typedef struct packed {
        t_order order;
        logic   zero_qty;
    } t_job;

    typedef enum logic [1:0] {
        BOP_NONE   = 2'd0,
        BOP_DEC    = 2'd1,
        BOP_DROP   = 2'd2,
        BOP_INSERT = 2'd3
    } t_book_op;

    typedef struct packed {
        t_book_op    op;
        logic [31:0] id;
        logic [19:0] price;
        logic [19:0] qty;
    } t_book_cmd;

    typedef struct packed {
        logic [31:0] id;
        logic [19:0] price;
        logic [19:0] qty;
    } t_entry;

    localparam int SIDE_SELL = 1;

endpackage
`default_nettype wire

FILE: rtl/core/lobm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry order queue between the command port and the matching engine.
module lobm_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire lobm_pkg::t_order i_order,
    output logic                 o_busy,
    output logic                 o_job_valid,
    output lobm_pkg::t_job       o_job,
    input  wire                  i_pop
);

    logic [1:0]     r_cnt, n_cnt;
    lobm_pkg::t_job r_q [2];
    lobm_pkg::t_job n_q [2];
    lobm_pkg::t_job w_new;
    logic           w_push;
    logic           w_pop;

    assign o_busy      = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[0];
    assign w_push      = i_start && !o_busy;
    assign w_pop       = i_pop && o_job_valid;

    always_comb begin
        w_new.order    = i_order;
        w_new.zero_qty = (i_order.quantity == 20'd0);
    end

    always_comb begin
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = r_cnt;
        if (w_pop) begin
            n_q[0] = r_q[1];
        end
        if (w_push) begin
            if ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop)) begin
                n_q[0] = w_new;
            end else begin
                n_q[1] = w_new;
            end
        end
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule
`default_nettype wire

FILE: rtl/core/lobm_book.sv
`timescale 1ns / 1ps
`default_nettype none
// One side of the book as a row of sorted cells, best at cell 0.
module lobm_book #(
    parameter int SLOTS  = 32,
    parameter bit IS_BID = 1'b1
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire lobm_pkg::t_book_cmd      i_cmd,
    output lobm_pkg::t_entry              o_head,
    output logic [$clog2(SLOTS+1)-1:0]    o_count,
    output logic                          o_full
);

    localparam int CW = $clog2(SLOTS + 1);

    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_id    [SLOTS];
    logic [19:0]   r_price [SLOTS];
    logic [19:0]   r_qty   [SLOTS];
    logic [31:0]   n_id    [SLOTS];
    logic [19:0]   n_price [SLOTS];
    logic [19:0]   n_qty   [SLOTS];
    logic [SLOTS-1:0] w_better;

    assign o_count       = r_count;
    assign o_full        = (r_count == CW'(SLOTS));
    assign o_head.id     = r_id[0];
    assign o_head.price  = r_price[0];
    assign o_head.qty    = r_qty[0];

    // a cell ranks ahead of the new order when it holds an equal or better price
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_better[i] = (CW'(i) < r_count) &&
                          (IS_BID ? (r_price[i] >= i_cmd.price)
                                  : (r_price[i] <= i_cmd.price));
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_id[i]    = r_id[i];
            n_price[i] = r_price[i];
            n_qty[i]   = r_qty[i];
        end
        n_count = r_count;
        case (i_cmd.op)
            lobm_pkg::BOP_DEC: begin
                n_qty[0] = r_qty[0] - i_cmd.qty;
            end
            lobm_pkg::BOP_DROP: begin
                for (int i = 0; i < SLOTS - 1; i++) begin
                    n_id[i]    = r_id[i+1];
                    n_price[i] = r_price[i+1];
                    n_qty[i]   = r_qty[i+1];
                end
                n_count = r_count - CW'(1);
            end
            lobm_pkg::BOP_INSERT: begin
                if (!w_better[0]) begin
                    n_id[0]    = i_cmd.id;
                    n_price[0] = i_cmd.price;
                    n_qty[0]   = i_cmd.qty;
                end
                for (int i = 1; i < SLOTS; i++) begin
                    if (!w_better[i]) begin
                        if (w_better[i-1]) begin
                            n_id[i]    = i_cmd.id;
                            n_price[i] = i_cmd.price;
                            n_qty[i]   = i_cmd.qty;
                        end else begin
                            n_id[i]    = r_id[i-1];
                            n_price[i] = r_price[i-1];
                            n_qty[i]   = r_qty[i-1];
                        end
                    end
                end
                n_count = r_count + CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        for (int i = 0; i < SLOTS; i++) begin
            r_id[i]    <= n_id[i];
            r_price[i] <= n_price[i];
            r_qty[i]   <= n_qty[i];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/lobm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Matching engine: one fill per cycle against the opposite head, then a status record.
module lobm_back #(
    parameter int SLOTS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_job_valid,
    input  wire lobm_pkg::t_job          i_job,
    output logic                         o_pop,
    output logic                         o_strobe,
    output lobm_pkg::t_result            o_result,
    output logic [$clog2(SLOTS+1)-1:0]   o_bid_count,
    output logic [$clog2(SLOTS+1)-1:0]   o_ask_count
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_id;
    logic        r_sell;
    logic [19:0] r_limit;
    logic [19:0] r_rem, n_rem;
    logic        r_strobe, n_strobe;
    lobm_pkg::t_result r_res, n_res;

    lobm_pkg::t_book_cmd w_bid_cmd, w_ask_cmd, w_opp_cmd, w_own_cmd;
    lobm_pkg::t_entry    w_bid_head, w_ask_head, w_opp;
    logic                w_bid_full, w_ask_full, w_own_full, w_opp_empty;
    logic                w_cross;
    logic [19:0]         w_fill;

    lobm_book #(.SLOTS(SLOTS), .IS_BID(1'b1)) u_bid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_bid_cmd),
        .o_head  (w_bid_head),
        .o_count (o_bid_count),
        .o_full  (w_bid_full)
    );

    lobm_book #(.SLOTS(SLOTS), .IS_BID(1'b0)) u_ask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_ask_cmd),
        .o_head  (w_ask_head),
        .o_count (o_ask_count),
        .o_full  (w_ask_full)
    );

    assign w_opp       = r_sell ? w_bid_head : w_ask_head;
    assign w_opp_empty = r_sell ? (o_bid_count == '0) : (o_ask_count == '0);
    assign w_own_full  = r_sell ? w_ask_full : w_bid_full;
    assign w_cross     = r_sell ? (w_opp.price >= r_limit) : (w_opp.price <= r_limit);
    assign w_fill      = (r_rem < w_opp.qty) ? r_rem : w_opp.qty;
    assign w_bid_cmd   = r_sell ? w_opp_cmd : w_own_cmd;
    assign w_ask_cmd   = r_sell ? w_own_cmd : w_opp_cmd;
    assign o_strobe    = r_strobe;
    assign o_result    = r_res;

    always_comb begin
        n_state         = r_state;
        n_rem           = r_rem;
        n_strobe        = 1'b0;
        n_res           = r_res;
        o_pop           = 1'b0;
        w_opp_cmd.op    = lobm_pkg::BOP_NONE;
        w_opp_cmd.id    = r_id;
        w_opp_cmd.price = r_limit;
        w_opp_cmd.qty   = w_fill;
        w_own_cmd.op    = lobm_pkg::BOP_NONE;
        w_own_cmd.id    = r_id;
        w_own_cmd.price = r_limit;
        w_own_cmd.qty   = r_rem;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_rem   = i_job.order.quantity;
                    n_state = i_job.zero_qty ? S_FINISH : S_MATCH;
                end
            end
            S_MATCH: begin
                if ((r_rem != 20'd0) && !w_opp_empty && w_cross) begin
                    n_strobe          = 1'b1;
                    n_res.kind        = lobm_pkg::KIND_TRADE;
                    n_res.buy_id      = r_sell ? w_opp.id : r_id;
                    n_res.sell_id     = r_sell ? r_id : w_opp.id;
                    n_res.trade_price = w_opp.price;
                    n_res.trade_qty   = w_fill;
                    n_res.last        = 1'b0;
                    n_rem             = r_rem - w_fill;
                    w_opp_cmd.op      = (w_fill == w_opp.qty) ? lobm_pkg::BOP_DROP
                                                              : lobm_pkg::BOP_DEC;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_strobe          = 1'b1;
                n_res.buy_id      = r_sell ? 32'd0 : r_id;
                n_res.sell_id     = r_sell ? r_id : 32'd0;
                n_res.trade_price = r_limit;
                n_res.trade_qty   = r_rem;
                n_res.last        = 1'b1;
                if (r_rem == 20'd0) begin
                    n_res.kind = lobm_pkg::KIND_FILLED;
                end else if (w_own_full) begin
                    n_res.kind = lobm_pkg::KIND_DROPPED;
                end else begin
                    n_res.kind   = lobm_pkg::KIND_RESTED;
                    w_own_cmd.op = lobm_pkg::BOP_INSERT;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_res <= n_res;
        r_rem <= n_rem;
        if (o_pop) begin
            r_id    <= i_job.order.order_id;
            r_sell  <= (i_job.order.side == 1'(lobm_pkg::SIDE_SELL));
            r_limit <= i_job.order.limit_price;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/limit_order_book_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Price-time priority matcher. An order is taken when i_start is high and o_busy low;
// a two-entry queue holds orders while the engine works. Each order passes through a load
// step, one fill per cycle against the opposite book head, a cross check that ends
// matching, and the status record with sorted insert; a zero quantity skips matching.
// Every result appears on o_result for exactly one cycle with o_strobe high and must be
// taken then; the receiver cannot stall. Trades carry last = 0, the final status
// record last = 1.
module limit_order_book_matcher #(
    parameter int BOOK_SLOTS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire lobm_pkg::t_order i_order,
    output logic                o_busy,
    output logic                o_strobe,
    output lobm_pkg::t_result   o_result
);

    localparam int CW = $clog2(BOOK_SLOTS + 1);

    logic           w_job_valid;
    lobm_pkg::t_job w_job;
    logic           w_pop;
    logic [CW-1:0]  w_bid_count, w_ask_count;

    lobm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_order     (i_order),
        .o_busy      (o_busy),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_pop       (w_pop)
    );

    lobm_back #(.SLOTS(BOOK_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .o_bid_count (w_bid_count),
        .o_ask_count (w_ask_count)
    );

    a_bid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bid_count <= CW'(BOOK_SLOTS))
        else $error("bid count beyond capacity");

    a_ask_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ask_count <= CW'(BOOK_SLOTS))
        else $error("ask count beyond capacity");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.last == (o_result.kind != lobm_pkg::KIND_TRADE)))
        else $error("last flag disagrees with record kind");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_job_valid)
        else $error("engine took an order from an empty queue");

endmodule
`default_nettype wire

FILE: tb/limit_order_book_matcher_tb.sv
`timescale 1ns / 1ps
module limit_order_book_matcher_tb;

    localparam int SLOTS     = 32;
    localparam int MAX_CYCLE = 400000;

    // book model plus the queue of expected trade and status records
    class match_board;
        logic [19:0] bid_px[$], bid_qt[$], ask_px[$], ask_qt[$];
        logic [31:0] bid_id[$], ask_id[$];
        lobm_pkg::t_result pending[$];
        int          errors;
        int          trades, rested, filled, dropped;

        function void add_order(lobm_pkg::t_order o);
            lobm_pkg::t_result r;
            logic [19:0] left, fill;
            int pos;
            bit is_sell;
            is_sell = (o.side == lobm_pkg::SIDE_SELL);
            left = o.quantity;
            while (left != 0 && (is_sell ? bid_px.size() : ask_px.size()) != 0) begin
                if (is_sell ? (bid_px[0] < o.limit_price) : (ask_px[0] > o.limit_price))
                    break;
                r.kind = lobm_pkg::KIND_TRADE;
                r.last = 1'b0;
                if (is_sell) begin
                    fill = (left < bid_qt[0]) ? left : bid_qt[0];
                    r.buy_id = bid_id[0];
                    r.sell_id = o.order_id;
                    r.trade_price = bid_px[0];
                    bid_qt[0] = bid_qt[0] - fill;
                    if (bid_qt[0] == 0) begin
                        void'(bid_px.pop_front());
                        void'(bid_qt.pop_front());
                        void'(bid_id.pop_front());
                    end
                end else begin
                    fill = (left < ask_qt[0]) ? left : ask_qt[0];
                    r.buy_id = o.order_id;
                    r.sell_id = ask_id[0];
                    r.trade_price = ask_px[0];
                    ask_qt[0] = ask_qt[0] - fill;
                    if (ask_qt[0] == 0) begin
                        void'(ask_px.pop_front());
                        void'(ask_qt.pop_front());
                        void'(ask_id.pop_front());
                    end
                end
                r.trade_qty = fill;
                left = left - fill;
                pending = {pending, r};
                trades++;
            end
            if (left == 0) begin
                r.kind = lobm_pkg::KIND_FILLED;
                filled++;
            end else if ((is_sell ? ask_px.size() : bid_px.size()) >= SLOTS) begin
                r.kind = lobm_pkg::KIND_DROPPED;
                dropped++;
            end else begin
                r.kind = lobm_pkg::KIND_RESTED;
                rested++;
                pos = 0;
                // new order goes behind equal prices
                if (is_sell) begin
                    while (pos < ask_px.size() && ask_px[pos] <= o.limit_price) pos++;
                    ask_px.insert(pos, o.limit_price);
                    ask_qt.insert(pos, left);
                    ask_id.insert(pos, o.order_id);
                end else begin
                    while (pos < bid_px.size() && bid_px[pos] >= o.limit_price) pos++;
                    bid_px.insert(pos, o.limit_price);
                    bid_qt.insert(pos, left);
                    bid_id.insert(pos, o.order_id);
                end
            end
            r.buy_id = is_sell ? 32'd0 : o.order_id;
            r.sell_id = is_sell ? o.order_id : 32'd0;
            r.trade_price = o.limit_price;
            r.trade_qty = left;
            r.last = 1'b1;
            pending = {pending, r};
        endfunction

        function void check_result(lobm_pkg::t_result got);
            lobm_pkg::t_result want;
            if (pending.size() == 0) begin
                $error("unexpected result kind=%0d", got.kind);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d actual %0d", want.kind, got.kind); errors++;
            end
            if (got.buy_id !== want.buy_id) begin
                $error("buy_id: expected %0h actual %0h", want.buy_id, got.buy_id); errors++;
            end
            if (got.sell_id !== want.sell_id) begin
                $error("sell_id: expected %0h actual %0h", want.sell_id, got.sell_id);
                errors++;
            end
            if (got.trade_price !== want.trade_price) begin
                $error("trade_price: expected %0d actual %0d", want.trade_price,
                       got.trade_price);
                errors++;
            end
            if (got.trade_qty !== want.trade_qty) begin
                $error("trade_qty: expected %0d actual %0d", want.trade_qty, got.trade_qty);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d actual %0d", want.last, got.last); errors++;
            end
        endfunction
    endclass

    logic    i_clk, i_rst_n, i_start;
    lobm_pkg::t_order  i_order;
    logic    o_busy, o_strobe;
    lobm_pkg::t_result o_result;
    match_board board;
    int      cycle;
    bit      no_idle;

    limit_order_book_matcher #(.BOOK_SLOTS(SLOTS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_order(i_order),
        .o_busy(o_busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n && o_strobe) board.check_result(o_result);
        if (cycle >= MAX_CYCLE) begin
            $display("limit_order_book_matcher verification failed");
            $finish;
        end
    end

    // one transfer; start stays high across back-to-back orders
    task automatic send_order(input lobm_pkg::t_order o);
        while (!no_idle && $urandom_range(99) < 32) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_order <= o;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.add_order(o);
    endtask

    task automatic send_fields(input logic [31:0] id, input logic sd,
                               input logic [19:0] px, input logic [19:0] qt);
        lobm_pkg::t_order o;
        o.order_id = id;
        o.side = sd;
        o.limit_price = px;
        o.quantity = qt;
        send_order(o);
    endtask

    task automatic send_random();
        logic [19:0] px, qt;
        int r;
        r = $urandom_range(99);
        // prices mostly near a common mid so orders cross
        if (r < 80) px = 20'(1000 + $urandom_range(20));
        else px = 20'($urandom);
        if (r % 7 == 0) qt = 20'($urandom);
        else if (r % 11 == 0) qt = 20'd0;
        else qt = 20'($urandom_range(1, 60));
        send_fields($urandom, 1'($urandom_range(1)), px, qt);
    endtask

    initial begin
        board = new();
        cycle = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_order = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero quantity, extreme fields, equal-price ordering, a sweep
        send_fields(32'hFFFF_FFFF, 1'b0, 20'hFFFFF, 20'd0);
        send_fields(32'h0, 1'b1, 20'd0, 20'd0);
        send_fields(32'h11, 1'b1, 20'd500, 20'd10);
        send_fields(32'h12, 1'b1, 20'd500, 20'd10);
        send_fields(32'h13, 1'b1, 20'd400, 20'd5);
        send_fields(32'h21, 1'b0, 20'd500, 20'd17);
        send_fields(32'h22, 1'b0, 20'd100, 20'hFFFFF);
        send_fields(32'h23, 1'b0, 20'd100, 20'd3);
        send_fields(32'h24, 1'b1, 20'd0, 20'd4);
        send_fields(32'h25, 1'b1, 20'd0, 20'hFFFFF);
        send_fields(32'h26, 1'b0, 20'hFFFFF, 20'hFFFFF);
        // fill the bid book past capacity, then sweep it
        for (int k = 0; k < SLOTS + 2; k++)
            send_fields(32'hA000 + 32'(k), 1'b0, 20'(10 + (k % 3)), 20'd1);
        send_fields(32'hB0, 1'b1, 20'd0, 20'hFFFFF);
        send_fields(32'hB1, 1'b1, 20'd5, 20'd1);

        for (int n = 0; n < 310; n++) begin
            no_idle = (n >= 100 && n < 180);
            send_random();
        end
        i_start <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("orders sent incl. full-book sweeps; trades %0d, rested %0d, filled %0d,",
                 board.trades, board.rested, board.filled);
        $display("dropped on full book %0d", board.dropped);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("limit_order_book_matcher verification clean");
        else
            $display("limit_order_book_matcher verification failed");
        $finish;
    end
endmodule

FILE: limit_order_book_matcher.f
rtl/core/lobm_pkg.sv
rtl/core/lobm_front.sv
rtl/core/lobm_book.sv
rtl/core/lobm_back.sv
rtl/core/limit_order_book_matcher.sv
tb/limit_order_book_matcher_tb.sv
